FILE: hw/rtl/modular_exponentiation_top_assert.svh
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modexp assertion failed");

// Check that cons holds in the cycle after ante.
`define MX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modexp assertion failed");

`endif

FILE: hw/rtl/modexp_pkg.sv
`timescale 1ns / 1ps
package modexp_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 31;
   localparam int RESIDUE_WIDTH = 31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_GO,
      ST_RED_WAIT,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

FILE: hw/rtl/modexp_mulmod.sv
`timescale 1ns / 1ps
module modexp_mulmod #(
   parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [OPERAND_WIDTH-1:0]  mult_a,
   input  logic [OPERAND_WIDTH-1:0]  mult_b,
   input  logic [OPERAND_WIDTH-1:0]  modulus,
   output modexp_pkg::mm_status_type status,
   output logic [OPERAND_WIDTH-1:0]  product
);
   import modexp_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int CW = $clog2(OPERAND_WIDTH + 1);

   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W+1:0]  sum;
   logic [W+1:0]  one_m;
   logic [W+1:0]  two_m;
   logic [W+1:0]  less_m;
   logic [W+1:0]  less_2m;
   logic [W-1:0]  step;

   // One multiplier bit per cycle: acc = 2*acc + bit*b, kept below m.
   always_comb begin
      one_m   = {2'b00, m_ff};
      two_m   = {1'b0, m_ff, 1'b0};
      sum     = {1'b0, acc_ff, 1'b0} + {2'b00, (a_ff[W-1] ? b_ff : {W{1'b0}})};
      less_m  = sum - one_m;
      less_2m = sum - two_m;
      priority if (sum >= two_m) begin
         step = less_2m[W-1:0];
      end else if (sum >= one_m) begin
         step = less_m[W-1:0];
      end else begin
         step = sum[W-1:0];
      end
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = mult_a;
         b_in    = mult_b;
         m_in    = modulus;
         acc_in  = {W{1'b0}};
         cnt_in  = CW'(OPERAND_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {a_ff[W-2:0], 1'b0};
         acc_in = step;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

FILE: hw/rtl/modular_exponentiation_top.sv
`timescale 1ns / 1ps
// Modular exponentiation: rsp_residue = req_base_value ** req_exponent mod req_modulus.
// Request channel (req_*): base, exponent and modulus, taken when req_valid is high
//   and req_stall is low. req_stall stays high from acceptance until the result is
//   handed to the response register, so one request is in work at a time.
// Response channel (rsp_*): one residue per request, held in an output register
//   while rsp_stall is high; a new request may be taken while it waits.
// Datapath: all work runs on one shift-add modular multiplier that consumes one
//   multiplier bit per cycle. A request runs the base reduction, then one squaring
//   per exponent bit (OPERAND_WIDTH bits) and one extra multiply per set bit.
// A modulus of zero gives a residue of zero; a modulus of one gives zero; exponent
//   zero gives one reduced by the modulus.
// Reset (synchronous, active high) returns the sequencer to idle and drops any
//   pending response; operand registers keep stale values that are never shown.
`include "modular_exponentiation_top_assert.svh"
module modular_exponentiation_top #(
   parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [OPERAND_WIDTH-1:0]             req_base_value,
   input  logic [OPERAND_WIDTH-1:0]             req_exponent,
   input  logic [OPERAND_WIDTH-1:0]             req_modulus,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [modexp_pkg::RESIDUE_WIDTH-1:0] rsp_residue
);
   import modexp_pkg::*;

   localparam int W    = OPERAND_WIDTH;
   localparam int BW   = $clog2(OPERAND_WIDTH);
   localparam int KEEP = (OPERAND_WIDTH < RESIDUE_WIDTH) ? OPERAND_WIDTH : RESIDUE_WIDTH;
   localparam logic [W-1:0] KEEP_MASK = W'((64'd1 << KEEP) - 64'd1);

   seq_state_type state_ff, state_in;

   logic [W-1:0]  base_ff, base_in;    // raw base
   logic [W-1:0]  exp_ff, exp_in;      // exponent, shifted left as bits are used
   logic [W-1:0]  mod_ff, mod_in;
   logic [W-1:0]  bred_ff, bred_in;    // base reduced by the modulus
   logic [W-1:0]  acc_ff, acc_in;      // running power
   logic [BW-1:0] bit_ff, bit_in;      // exponent bits left, minus one
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RESIDUE_WIDTH-1:0] rsp_residue_ff, rsp_residue_in;

   logic          req_take;
   logic          rsp_take;
   logic          rsp_free;
   logic          mm_start;
   logic [W-1:0]  mm_a;
   logic [W-1:0]  mm_b;
   logic [W-1:0]  mm_product;
   logic [W-1:0]  one_mod;
   mm_status_type mm_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // One reduced by the modulus; a modulus of one gives zero.
   assign one_mod = (mod_ff == W'(1)) ? {W{1'b0}} : W'(1);

   modexp_mulmod #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .mult_a  (mm_a),
      .mult_b  (mm_b),
      .modulus (mod_ff),
      .status  (mm_status),
      .product (mm_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff        <= base_in;
      exp_ff         <= exp_in;
      mod_ff         <= mod_in;
      bred_ff        <= bred_in;
      acc_ff         <= acc_in;
      bit_ff         <= bit_in;
      rsp_residue_ff <= rsp_residue_in;
   end

   // Sequencer: reduce the base, then square per exponent bit and multiply on ones.
   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      exp_in         = exp_ff;
      mod_in         = mod_ff;
      bred_in        = bred_ff;
      acc_in         = acc_ff;
      bit_in         = bit_ff;
      rsp_valid_in   = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_residue_in = rsp_residue_ff;
      mm_start       = 1'b0;
      mm_a           = acc_ff;
      mm_b           = acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               base_in  = req_base_value;
               exp_in   = req_exponent;
               mod_in   = req_modulus;
               bit_in   = BW'(OPERAND_WIDTH - 1);
               state_in = ST_RED_GO;
            end
         end
         ST_RED_GO: begin
            // base * (1 mod m) reduces the base through the shared multiplier
            mm_start = 1'b1;
            mm_a     = base_ff;
            mm_b     = one_mod;
            state_in = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            if (mm_status.done) begin
               bred_in  = mm_product;
               acc_in   = one_mod;
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            mm_start = 1'b1;
            mm_a     = acc_ff;
            mm_b     = acc_ff;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (mm_status.done) begin
               acc_in = mm_product;
               if (exp_ff[W-1]) begin
                  state_in = ST_MUL_GO;
               end else if (bit_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  exp_in   = {exp_ff[W-2:0], 1'b0};
                  bit_in   = bit_ff - BW'(1);
                  state_in = ST_SQ_GO;
               end
            end
         end
         ST_MUL_GO: begin
            mm_start = 1'b1;
            mm_a     = acc_ff;
            mm_b     = bred_ff;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mm_status.done) begin
               acc_in = mm_product;
               if (bit_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  exp_in   = {exp_ff[W-2:0], 1'b0};
                  bit_in   = bit_ff - BW'(1);
                  state_in = ST_SQ_GO;
               end
            end
         end
         ST_DONE: begin
            // hold the result until the response register is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_residue_in = (mod_ff == '0) ? {RESIDUE_WIDTH{1'b0}} :
                                RESIDUE_WIDTH'(acc_ff & KEEP_MASK);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

   // An accepted request always starts with the base reduction.
   `MX_ASSERT_NEXT(a_req_starts_reduce, clock, reset, req_take, state_ff == ST_RED_GO)
   // The multiplier only runs or finishes while the sequencer waits on it.
   `MX_ASSERT_SAME(a_mm_in_wait, clock, reset, mm_status.busy || mm_status.done,
      state_ff == ST_RED_WAIT || state_ff == ST_SQ_WAIT || state_ff == ST_MUL_WAIT)
   // A zero modulus yields a zero residue.
   `MX_ASSERT_NEXT(a_zero_modulus, clock, reset,
      state_ff == ST_DONE && rsp_free && mod_ff == '0, rsp_valid && rsp_residue == '0)

endmodule
